@@ design/lzss_nl_pkg.sv @@
// Package for the LZSS nibble-length decompressor.
// Holds the transaction payload structs and fixed stream constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lzss_nl_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       stream_done;
  } out_t;

  localparam logic [2:0] HDR_BYTES = 3'd4;
  localparam logic [4:0] MIN_MATCH = 5'd2;
  localparam logic [3:0] NIB_MASK  = 4'hF;
  localparam logic [2:0] POS_MASK  = 3'd7;

endpackage

`default_nettype wire

@@ design/lzss_nibble_length_decompressor.sv @@
// LZSS decompressor with nibble-coded match lengths, top level.
// Depends on lzss_nl_pkg.
//
// Usage: compressed bytes arrive on the in_* channel, one per transaction;
// stream_start marks the first header byte of a stream and drops any old state.
// Decompressed bytes leave on the out_* channel, one per transaction, with
// last_of_run on the final byte caused by one input byte and stream_done once
// the header length has been reached.
// Latency and throughput: header, flag and nibble bytes are absorbed on
// acceptance. A literal appears on the output the cycle after acceptance. A
// distance byte with a match of L bytes (2..17) goes through its acceptance,
// the registered read of the 256-entry history RAM, a copy of one byte per
// cycle while the receiver does not stall, and a token step for the next token
// decision. The history RAM port sets this rate.
// Input is taken only while no match copy is running and the output register
// is free or being drained in the same cycle.
// Reset: decoder state returns to the header phase; the history RAM is not
// cleared, and references to never-written entries are undefined.
// Receiver stall: the output register holds its byte and the copy pauses with
// its read data parked; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module lzss_nibble_length_decompressor
  import lzss_nl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire in_t  in_data_i,
  output      logic out_valid_o,
  input  wire logic out_ready_i,
  output      out_t out_data_o
);

  typedef enum logic [2:0] {
    K_HEADER,
    K_FLAG,
    K_NIBBLE,
    K_LITERAL,
    K_DIST,
    K_DONE
  } kind_e;

  typedef enum logic [1:0] {
    ST_IN,
    ST_COPY,
    ST_TOKEN
  } state_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] flag;
    logic [2:0] pos;
    logic [7:0] nib;
    logic       half;
    logic [4:0] pend;
  } tok_t;

  localparam tok_t TOK_CLEAR = '{kind: K_HEADER, flag: 8'h00, pos: 3'd0,
                                 nib: 8'h00, half: 1'b0, pend: 5'd0};

  function automatic tok_t decide(tok_t t);
    tok_t r;
    r = t;
    if (r.flag[0]) begin
      r.kind = K_LITERAL;
    end else if (!r.half) begin
      r.kind = K_NIBBLE;
    end else begin
      r.nib  = {4'h0, r.nib[7:4]};
      r.half = 1'b0;
      r.pend = {1'b0, r.nib[3:0] & NIB_MASK} + MIN_MATCH;
      r.kind = K_DIST;
    end
    return r;
  endfunction

  function automatic tok_t next_tok(tok_t t, logic ge);
    tok_t r;
    r = t;
    if (ge) begin
      r.kind = K_DONE;
    end else if (r.pos == 3'd0) begin
      r.kind = K_FLAG;
    end else begin
      r.flag = {1'b0, r.flag[7:1]};
      r.pos  = (r.pos + 3'd1) & POS_MASK;
      r     = decide(r);
    end
    return r;
  endfunction

  state_e      st_q, st_d;
  tok_t        tok_q, tok_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] tgt_q, tgt_d;
  logic [2:0]  hdr_q, hdr_d;
  logic [7:0]  src_q, src_d;
  logic [4:0]  iss_q, iss_d;
  logic [4:0]  rem_q, rem_d;
  logic        rd_pend_q, rd_pend_d;
  logic        out_valid_q, out_valid_d;
  out_t        out_q, out_d;

  logic [7:0]  hist_mem [256];
  logic [7:0]  rdata_q;
  logic        we, rd_en, adv;
  logic [7:0]  waddr, wdata, raddr;
  logic [31:0] cinc;

  assign adv         = !out_valid_q || out_ready_i;
  assign in_ready_o  = (st_q == ST_IN) && adv;
  assign cinc        = cnt_q + 32'd1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    tok_t        t;
    logic [31:0] c;
    logic [31:0] g;
    logic [2:0]  h;
    logic [7:0]  b;

    st_d        = st_q;
    tok_d       = tok_q;
    cnt_d       = cnt_q;
    tgt_d       = tgt_q;
    hdr_d       = hdr_q;
    src_d       = src_q;
    iss_d       = iss_q;
    rem_d       = rem_q;
    rd_pend_d   = rd_pend_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    waddr       = cnt_q[7:0];
    wdata       = rdata_q;
    rd_en       = 1'b0;
    raddr       = src_q;

    t = tok_q;
    c = cnt_q;
    g = tgt_q;
    h = hdr_q;
    b = in_data_i.in_byte;

    case (st_q)
      ST_IN: begin
        if (in_valid_i && adv) begin
          if (in_data_i.stream_start) begin
            t = TOK_CLEAR;
            c = 32'd0;
            g = 32'd0;
            h = 3'd0;
          end
          case (t.kind)
            K_HEADER: begin
              g = g | ({24'h0, b} << {h[1:0], 3'b000});
              h = h + 3'd1;
              if (h >= HDR_BYTES) begin
                t = next_tok(t, c >= g);
              end
            end
            K_FLAG: begin
              t.flag = b;
              t.pos  = 3'd1;
              t      = decide(t);
            end
            K_NIBBLE: begin
              t.nib  = b;
              t.half = 1'b1;
              t.pend = {1'b0, b[3:0] & NIB_MASK} + MIN_MATCH;
              t.kind = K_DIST;
            end
            K_LITERAL: begin
              we          = 1'b1;
              waddr       = c[7:0];
              wdata       = b;
              c           = c + 32'd1;
              out_valid_d = 1'b1;
              out_d       = '{out_byte: b, last_of_run: 1'b1, stream_done: (c >= g)};
              t           = next_tok(t, c >= g);
            end
            K_DIST: begin
              src_d  = c[7:0] - b - 8'd1;
              iss_d  = t.pend;
              rem_d  = t.pend;
              t.pend = 5'd0;
              st_d   = ST_COPY;
            end
            K_DONE: begin
              t.kind = K_DONE;
            end
            default: begin
              t.kind = K_DONE;
            end
          endcase
          tok_d = t;
          cnt_d = c;
          tgt_d = g;
          hdr_d = h;
        end
      end
      ST_COPY: begin
        if (rd_pend_q && adv) begin
          we          = 1'b1;
          wdata       = rdata_q;
          out_valid_d = 1'b1;
          out_d       = '{out_byte: rdata_q, last_of_run: (rem_q == 5'd1),
                          stream_done: (cinc >= tgt_q)};
          cnt_d       = cinc;
          rem_d       = rem_q - 5'd1;
          rd_pend_d   = 1'b0;
          if (rem_q == 5'd1) begin
            st_d = ST_TOKEN;
          end
        end
        if (iss_q != 5'd0 && (!rd_pend_q || adv)) begin
          rd_en     = 1'b1;
          src_d     = src_q + 8'd1;
          iss_d     = iss_q - 5'd1;
          rd_pend_d = 1'b1;
        end
      end
      ST_TOKEN: begin
        tok_d = next_tok(tok_q, cnt_q >= tgt_q);
        st_d  = ST_IN;
      end
      default: begin
        st_d = ST_IN;
      end
    endcase
  end

  // history RAM, write-first on a same-address read
  always_ff @(posedge clk_i) begin
    if (we) begin
      hist_mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= (we && (waddr == raddr)) ? wdata : hist_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IN;
      tok_q       <= TOK_CLEAR;
      cnt_q       <= 32'd0;
      tgt_q       <= 32'd0;
      hdr_q       <= 3'd0;
      src_q       <= 8'd0;
      iss_q       <= 5'd0;
      rem_q       <= 5'd0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      tok_q       <= tok_d;
      cnt_q       <= cnt_d;
      tgt_q       <= tgt_d;
      hdr_q       <= hdr_d;
      src_q       <= src_d;
      iss_q       <= iss_d;
      rem_q       <= rem_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  a_pend_in_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> st_q == ST_COPY)
    else $error("read data pending outside a copy");

  a_copy_counts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_COPY |-> rem_q != 5'd0 && iss_q <= rem_q)
    else $error("copy counters inconsistent");

  a_token_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_TOKEN |-> !rd_pend_q && iss_q == 5'd0 && rem_q == 5'd0)
    else $error("token step with copy work outstanding");

  a_copy_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_COPY && rd_pend_q && adv && rem_q == 5'd1 |=>
      out_valid_q && out_q.last_of_run && st_q == ST_TOKEN)
    else $error("final copy byte not flagged");

endmodule

`default_nettype wire
